// File: src/hsl_to_rgb_converter_macros.svh
// ---------------------------------------------------------------------------
// hsl to rgb converter assertion macros
// shared concurrent assertion forms for the converter pipeline
// ---------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication
`define HSLRGB_ASSERT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("hslrgb assertion failed");

// next-cycle implication
`define HSLRGB_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("hslrgb assertion failed");

`endif

// File: src/hslrgb_pkg.sv
// ---------------------------------------------------------------------------
// hslrgb_pkg
// widths, payload types and stage records of the hsl to rgb converter
// ---------------------------------------------------------------------------
`default_nettype none

package hslrgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HUE_BITS  = 16;
  localparam int UW        = FRAC_BITS + 1;
  localparam int FW        = HUE_BITS + 1;
  localparam int HP_W      = HUE_BITS + 3;
  localparam int SW        = UW + 3;

  localparam logic [UW-1:0] ONE  = UW'(1) << FRAC_BITS;
  localparam logic [UW-1:0] HALF = UW'(1) << (FRAC_BITS - 1);

  localparam logic [2:0] SECT_RY = 3'd0;
  localparam logic [2:0] SECT_YG = 3'd1;
  localparam logic [2:0] SECT_GC = 3'd2;
  localparam logic [2:0] SECT_CB = 3'd3;
  localparam logic [2:0] SECT_BM = 3'd4;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [UW-1:0]       saturation;
    logic [UW-1:0]       lightness;
  } hsl_t;

  typedef struct packed {
    logic [UW-1:0] red;
    logic [UW-1:0] green;
    logic [UW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [UW-1:0] om;
    logic [UW-1:0] sat;
    logic [UW-1:0] light;
    logic [2:0]    sector;
    logic [FW-1:0] weight;
  } prep_t;

  typedef struct packed {
    logic [UW-1:0] chroma;
    logic [UW-1:0] light;
    logic [2:0]    sector;
    logic [FW-1:0] weight;
  } chroma_t;

  typedef struct packed {
    logic [UW-1:0] chroma;
    logic [UW-1:0] second;
    logic [UW-1:0] light;
    logic [2:0]    sector;
  } mixin_t;

endpackage

`default_nettype wire

// File: src/hslrgb_prep.sv
// ---------------------------------------------------------------------------
// hslrgb_prep
// input clamp, lightness fold, hue sector split and secondary weight
// ---------------------------------------------------------------------------
`default_nettype none

module hslrgb_prep (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hslrgb_pkg::hsl_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hslrgb_pkg::prep_t      out_data
);

  logic [hslrgb_pkg::UW-1:0]   s_cl;
  logic [hslrgb_pkg::UW-1:0]   l_cl;
  logic [hslrgb_pkg::UW:0]     twol;
  logic [hslrgb_pkg::UW:0]     fold;
  logic [hslrgb_pkg::UW:0]     om_w;
  logic [hslrgb_pkg::HP_W-1:0] hp;
  logic [2:0]                  sector;
  logic [hslrgb_pkg::FW-1:0]   frac;
  hslrgb_pkg::prep_t           data_next;

  always_comb begin
    s_cl = (in_data.saturation > hslrgb_pkg::ONE) ? hslrgb_pkg::ONE : in_data.saturation;
    l_cl = (in_data.lightness > hslrgb_pkg::ONE) ? hslrgb_pkg::ONE : in_data.lightness;
    twol = {l_cl, 1'b0};
    if (twol >= {1'b0, hslrgb_pkg::ONE}) begin
      fold = twol - {1'b0, hslrgb_pkg::ONE};
    end else begin
      fold = {1'b0, hslrgb_pkg::ONE} - twol;
    end
    om_w   = {1'b0, hslrgb_pkg::ONE} - fold;
    hp     = {1'b0, in_data.hue, 2'b00} + {2'b00, in_data.hue, 1'b0};
    sector = hp[hslrgb_pkg::HP_W-1 -: 3];
    frac   = {1'b0, hp[hslrgb_pkg::HUE_BITS-1:0]};
    data_next.om    = om_w[hslrgb_pkg::UW-1:0];
    data_next.sat   = s_cl;
    data_next.light = l_cl;
    data_next.sector = sector;
    if (sector[0]) begin
      data_next.weight = (hslrgb_pkg::FW'(1) << hslrgb_pkg::HUE_BITS) - frac;
    end else begin
      data_next.weight = frac;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: src/hslrgb_chroma.sv
// ---------------------------------------------------------------------------
// hslrgb_chroma
// two multiplier stages: chroma from fold and saturation, then secondary
// ---------------------------------------------------------------------------
`default_nettype none

`include "hsl_to_rgb_converter_macros.svh"

module hslrgb_chroma (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hslrgb_pkg::prep_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hslrgb_pkg::mixin_t      out_data
);

  localparam int PW1 = 2 * hslrgb_pkg::UW;
  localparam int PW2 = hslrgb_pkg::UW + hslrgb_pkg::FW;

  logic [PW1-1:0]           prod_c;
  logic [PW1-1:0]           round_c;
  logic [PW2-1:0]           prod_x;
  logic [PW2-1:0]           round_x;
  hslrgb_pkg::chroma_t      mid_next;
  hslrgb_pkg::chroma_t      mid;
  logic                     mid_valid;
  logic                     mid_ready;
  hslrgb_pkg::mixin_t       data_next;

  // chroma stage
  always_comb begin
    prod_c  = PW1'(in_data.om) * PW1'(in_data.sat);
    round_c = prod_c + PW1'(hslrgb_pkg::HALF);
    mid_next.chroma = round_c[hslrgb_pkg::FRAC_BITS +: hslrgb_pkg::UW];
    mid_next.light  = in_data.light;
    mid_next.sector = in_data.sector;
    mid_next.weight = in_data.weight;
  end

  assign in_ready = !mid_valid || mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_ready) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mid <= mid_next;
    end
  end

  // secondary stage
  always_comb begin
    prod_x  = PW2'(mid.chroma) * PW2'(mid.weight);
    round_x = prod_x + (PW2'(1) << (hslrgb_pkg::HUE_BITS - 1));
    data_next.second = round_x[hslrgb_pkg::HUE_BITS +: hslrgb_pkg::UW];
    data_next.chroma = mid.chroma;
    data_next.light  = mid.light;
    data_next.sector = mid.sector;
  end

  assign mid_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      out_data <= data_next;
    end
  end

  `HSLRGB_ASSERT(a_chroma_le_one, clk, rst, mid_valid, mid.chroma <= hslrgb_pkg::ONE)
  `HSLRGB_ASSERT(a_second_le_chroma, clk, rst, out_valid, out_data.second <= out_data.chroma)
  `HSLRGB_ASSERT_NEXT(a_mid_moves_on, clk, rst, mid_valid && mid_ready, out_valid)

endmodule

`default_nettype wire

// File: src/hslrgb_mix.sv
// ---------------------------------------------------------------------------
// hslrgb_mix
// lightness match, halving with saturation and sector placement
// ---------------------------------------------------------------------------
`default_nettype none

`include "hsl_to_rgb_converter_macros.svh"

module hslrgb_mix (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hslrgb_pkg::mixin_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hslrgb_pkg::rgb_t         out_data
);

  function automatic logic [hslrgb_pkg::UW-1:0] halve_sat(
    input logic signed [hslrgb_pkg::SW-1:0] twice
  );
    logic signed [hslrgb_pkg::SW-1:0] v;
    logic [hslrgb_pkg::UW-1:0]        res;
    v = (twice + hslrgb_pkg::SW'(1)) >>> 1;
    if (twice < 0) begin
      res = '0;
    end else if (v > $signed({3'b000, hslrgb_pkg::ONE})) begin
      res = hslrgb_pkg::ONE;
    end else begin
      res = v[hslrgb_pkg::UW-1:0];
    end
    return res;
  endfunction

  logic signed [hslrgb_pkg::SW-1:0] l2;
  logic signed [hslrgb_pkg::SW-1:0] c1;
  logic signed [hslrgb_pkg::SW-1:0] c2;
  logic signed [hslrgb_pkg::SW-1:0] x2;
  logic signed [hslrgb_pkg::SW-1:0] lm2;
  logic [hslrgb_pkg::UW-1:0]        pm;
  logic [hslrgb_pkg::UW-1:0]        pc;
  logic [hslrgb_pkg::UW-1:0]        px;
  hslrgb_pkg::rgb_t                 data_next;
  logic                             rgb_in_range;

  always_comb begin
    l2  = $signed({2'b00, in_data.light, 1'b0});
    c1  = $signed({3'b000, in_data.chroma});
    c2  = $signed({2'b00, in_data.chroma, 1'b0});
    x2  = $signed({2'b00, in_data.second, 1'b0});
    lm2 = l2 - c1;
    pm  = halve_sat(lm2);
    pc  = halve_sat(lm2 + c2);
    px  = halve_sat(lm2 + x2);
    unique case (in_data.sector)
      hslrgb_pkg::SECT_RY: data_next = '{red: pc, green: px, blue: pm};
      hslrgb_pkg::SECT_YG: data_next = '{red: px, green: pc, blue: pm};
      hslrgb_pkg::SECT_GC: data_next = '{red: pm, green: pc, blue: px};
      hslrgb_pkg::SECT_CB: data_next = '{red: pm, green: px, blue: pc};
      hslrgb_pkg::SECT_BM: data_next = '{red: px, green: pm, blue: pc};
      default:             data_next = '{red: pc, green: pm, blue: px};
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

  assign rgb_in_range = (out_data.red <= hslrgb_pkg::ONE) &&
                        (out_data.green <= hslrgb_pkg::ONE) &&
                        (out_data.blue <= hslrgb_pkg::ONE);

  `HSLRGB_ASSERT(a_rgb_in_range, clk, rst, out_valid, rgb_in_range)

endmodule

`default_nettype wire

// File: src/hsl_to_rgb_converter.sv
// ---------------------------------------------------------------------------
// hsl_to_rgb_converter
// fixed-point hsl to rgb colour conversion, top level
// ---------------------------------------------------------------------------
// Takes one pixel per clock on the hsl channel when the output is not
// stalled, and holds it in four register stages:
// one stage folds lightness and splits the hue into sector and fraction, two
// stages each hold one multiplier (chroma, then the secondary component), and
// the last stage forms the three channels and places them by sector. Each
// stage holds one pixel and moves on whenever the stage after it is free, so
// a stall on the rgb side backs up stage by stage without losing a pixel.
// Saturation and lightness above one are treated as one; outputs lie in
// 0..one with one at bit FRAC_BITS.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              hsl_valid,
  output logic                   hsl_ready,
  input  wire hslrgb_pkg::hsl_t  hsl,
  output logic                   rgb_valid,
  input  wire logic              rgb_ready,
  output hslrgb_pkg::rgb_t       rgb
);

  hslrgb_pkg::prep_t  prep_data;
  logic               prep_valid;
  logic               prep_ready;
  hslrgb_pkg::mixin_t mix_data;
  logic               mix_valid;
  logic               mix_ready;
  logic               all_full;

  hslrgb_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsl_valid),
    .in_ready  (hsl_ready),
    .in_data   (hsl),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  hslrgb_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_data  (mix_data)
  );

  hslrgb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_data   (mix_data),
    .out_valid (rgb_valid),
    .out_ready (rgb_ready),
    .out_data  (rgb)
  );

  assign all_full = prep_valid && mix_valid && rgb_valid && !rgb_ready;

  // input held off only when every stage is full and the output stalls
  `HSLRGB_ASSERT(a_full_when_blocked, clk, rst, !hsl_ready, all_full)

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsl to rgb converter testbench
// ---------------------------------------------------------------------------
// Feeds pixels through the hsl channel from a queue and predicts each rgb
// result at its transfer. A monitor checks every rgb transfer in order
// against the prediction. It starts with a directed set: hue sector edges,
// the odd sector at fraction zero, grey, black, white, and saturation and
// lightness above one. A random set follows. Both sides idle in random
// bursts, except near the end of the run.
// ---------------------------------------------------------------------------

module testbench;

  localparam int RANDOM_ITEMS = 1300;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [hslrgb_pkg::UW-1:0] IN_MASK = {hslrgb_pkg::UW{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hsl_valid = 1'b0;
  logic hsl_ready;
  hslrgb_pkg::hsl_t hsl = '0;
  logic rgb_valid;
  logic rgb_ready = 1'b0;
  hslrgb_pkg::rgb_t rgb;

  hslrgb_pkg::hsl_t pending_pixels[$];
  hslrgb_pkg::rgb_t expected_rgb[$];
  int   send_gap = 0;
  int   recv_stall = 0;
  int   pixels_sent = 0;
  int   pixels_checked = 0;
  int   directed_count = 0;
  int   error_count = 0;
  int   cycle_count = 0;

  hsl_to_rgb_converter u_dut (
    .clk       (clk),
    .rst       (rst),
    .hsl_valid (hsl_valid),
    .hsl_ready (hsl_ready),
    .hsl       (hsl),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // half units back to output units, rounded half up and saturated
  function automatic logic [hslrgb_pkg::UW-1:0] halve_clip(int twice);
    int v;
    if (twice < 0) return '0;
    v = (twice + 1) / 2;
    if (v > int'(hslrgb_pkg::ONE)) return hslrgb_pkg::ONE;
    return hslrgb_pkg::UW'(v);
  endfunction

  function automatic hslrgb_pkg::rgb_t hsl_to_rgb_expected(hslrgb_pkg::hsl_t px);
    logic [hslrgb_pkg::UW-1:0]               s, l, fold, span, chroma, second, pm, pc, pxs;
    logic [hslrgb_pkg::UW:0]                 twice_l;
    logic [2*hslrgb_pkg::UW-1:0]             prod;
    logic [hslrgb_pkg::HP_W-1:0]             hp;
    logic [2:0]                              sector;
    logic [hslrgb_pkg::HUE_BITS-1:0]         frac;
    logic [hslrgb_pkg::FW-1:0]               weight;
    logic [hslrgb_pkg::UW+hslrgb_pkg::FW-1:0] xprod;
    int                                      lm2;
    hslrgb_pkg::rgb_t                        res;
    s = (px.saturation > hslrgb_pkg::ONE) ? hslrgb_pkg::ONE : px.saturation;
    l = (px.lightness > hslrgb_pkg::ONE) ? hslrgb_pkg::ONE : px.lightness;
    twice_l = {l, 1'b0};
    if (twice_l >= hslrgb_pkg::ONE) fold = hslrgb_pkg::UW'(twice_l - hslrgb_pkg::ONE);
    else fold = hslrgb_pkg::UW'(hslrgb_pkg::ONE - twice_l);
    span = hslrgb_pkg::ONE - fold;
    prod = span * s;
    chroma = hslrgb_pkg::UW'((prod + hslrgb_pkg::HALF) >> hslrgb_pkg::FRAC_BITS);
    hp = hslrgb_pkg::HP_W'(px.hue) * hslrgb_pkg::HP_W'(6);
    sector = hp[hslrgb_pkg::HP_W-1:hslrgb_pkg::HUE_BITS];
    frac = hp[hslrgb_pkg::HUE_BITS-1:0];
    if (sector[0])
      weight = (hslrgb_pkg::FW'(1) << hslrgb_pkg::HUE_BITS) - hslrgb_pkg::FW'(frac);
    else weight = hslrgb_pkg::FW'(frac);
    xprod = chroma * weight;
    second = hslrgb_pkg::UW'((xprod + (1 << (hslrgb_pkg::HUE_BITS - 1)))
                             >> hslrgb_pkg::HUE_BITS);
    lm2 = 2 * int'(l) - int'(chroma);
    pm  = halve_clip(lm2);
    pc  = halve_clip(lm2 + 2 * int'(chroma));
    pxs = halve_clip(lm2 + 2 * int'(second));
    case (sector)
      hslrgb_pkg::SECT_RY: res = '{red: pc,  green: pxs, blue: pm};
      hslrgb_pkg::SECT_YG: res = '{red: pxs, green: pc,  blue: pm};
      hslrgb_pkg::SECT_GC: res = '{red: pm,  green: pc,  blue: pxs};
      hslrgb_pkg::SECT_CB: res = '{red: pm,  green: pxs, blue: pc};
      hslrgb_pkg::SECT_BM: res = '{red: pxs, green: pm,  blue: pc};
      default:             res = '{red: pc,  green: pm,  blue: pxs};
    endcase
    return res;
  endfunction

  function automatic logic [hslrgb_pkg::UW-1:0] pick_unit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return hslrgb_pkg::ONE;
      2: return hslrgb_pkg::UW'($urandom) & IN_MASK;
      3: return hslrgb_pkg::ONE + hslrgb_pkg::UW'($urandom_range(1, 16));
      4: return hslrgb_pkg::HALF + hslrgb_pkg::UW'($urandom_range(0, 8)) - hslrgb_pkg::UW'(4);
      default: return hslrgb_pkg::UW'($urandom_range(0, 65536));
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      hsl_valid <= 1'b0;
    end else begin
      if (hsl_valid && hsl_ready) begin
        expected_rgb.push_back(hsl_to_rgb_expected(hsl));
        pixels_sent++;
      end
      if (!hsl_valid || hsl_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          hsl_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          hsl <= pending_pixels.pop_front();
          hsl_valid <= 1'b1;
          if (pending_pixels.size() >= TAIL_ITEMS && $urandom_range(0, 6) == 0)
            send_gap = $urandom_range(1, 18);
        end else begin
          hsl_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hslrgb_pkg::rgb_t want;
    if (rst) begin
      rgb_ready <= 1'b0;
    end else begin
      if (rgb_valid && rgb_ready) begin
        if (expected_rgb.size() == 0) begin
          $error("rgb transfer with no pixel outstanding");
          error_count++;
        end else begin
          want = expected_rgb.pop_front();
          pixels_checked++;
          if (rgb.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, rgb.red);
            error_count++;
          end
          if (rgb.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, rgb.green);
            error_count++;
          end
          if (rgb.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, rgb.blue);
            error_count++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rgb_ready <= 1'b0;
      end else begin
        rgb_ready <= 1'b1;
        if (pending_pixels.size() >= TAIL_ITEMS && $urandom_range(0, 6) == 0)
          recv_stall = $urandom_range(1, 18);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [hslrgb_pkg::HUE_BITS-1:0] edge_hues[8];
    hslrgb_pkg::hsl_t px;
    edge_hues = '{16'd0, 16'd10922, 16'd10923, 16'd21845,
                  16'd32768, 16'd43690, 16'd54613, 16'd65535};
    foreach (edge_hues[i])
      pending_pixels.push_back('{hue: edge_hues[i], saturation: hslrgb_pkg::ONE,
                                 lightness: hslrgb_pkg::HALF});
    pending_pixels.push_back('{hue: 16'd0,     saturation: '0, lightness: '0});
    pending_pixels.push_back('{hue: 16'd1000,  saturation: '0, lightness: 17'd40000});
    pending_pixels.push_back('{hue: 16'd5000,  saturation: hslrgb_pkg::ONE, lightness: '0});
    pending_pixels.push_back('{hue: 16'd5000,  saturation: hslrgb_pkg::ONE,
                               lightness: hslrgb_pkg::ONE});
    pending_pixels.push_back('{hue: 16'd32768, saturation: IN_MASK, lightness: IN_MASK});
    pending_pixels.push_back('{hue: 16'd20000, saturation: hslrgb_pkg::ONE + 1'b1,
                               lightness: 17'd30000});
    pending_pixels.push_back('{hue: 16'd32768, saturation: 17'd40000, lightness: 17'd20000});
    pending_pixels.push_back('{hue: 16'd60000, saturation: 17'd50000, lightness: 17'd98304});
    pending_pixels.push_back('{hue: 16'd12345, saturation: 17'd30000,
                               lightness: hslrgb_pkg::HALF - 1'b1});
    pending_pixels.push_back('{hue: 16'd45000, saturation: hslrgb_pkg::ONE,
                               lightness: hslrgb_pkg::HALF + 1'b1});
    pending_pixels.push_back('{hue: 16'hAAAA,  saturation: 17'h15555, lightness: 17'h0AAAA});
    directed_count = pending_pixels.size();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 7))
        0: px.hue = hslrgb_pkg::HUE_BITS'($urandom_range(0, 5) * 10923
                                          + $urandom_range(0, 6)) - 16'd3;
        1: px.hue = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: px.hue = hslrgb_pkg::HUE_BITS'($urandom);
      endcase
      px.saturation = pick_unit();
      px.lightness  = pick_unit();
      pending_pixels.push_back(px);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() > 0 || hsl_valid) @(posedge clk);
    while (expected_rgb.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pixels sent, %0d checked (%0d directed, %0d random)",
             pixels_sent, pixels_checked, directed_count, RANDOM_ITEMS);
    $display("all hue sectors and edges, clamped inputs, idle bursts on both sides");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
